FILE: sv/sbs_pkg.sv
`default_nettype none

package sbs_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FIELD_W     = 8;
    localparam int WORD_W      = 32;
    localparam int CMP_W       = ((IDX_W > FIELD_W) ? IDX_W : FIELD_W) + 1;

    localparam logic [CMP_W-1:0] LAST_IDX = CMP_W'(TABLE_DEPTH - 1);

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef logic [IDX_W-1:0]          t_idx;
    typedef logic [FIELD_W-1:0]        t_field;
    typedef logic signed [WORD_W-1:0]  t_word;
    typedef logic [CMP_W-1:0]          t_cmp;

    typedef struct packed {
        logic  we;
        t_idx  waddr;
        t_word wdata;
        t_idx  raddr;
    } t_mem_req;

    function automatic t_cmp field_ext(input t_field f);
        return CMP_W'(f);
    endfunction

    function automatic t_field idx_to_field(input t_idx i);
        t_cmp e;
        e = CMP_W'(i);
        return e[FIELD_W-1:0];
    endfunction

    function automatic t_idx mid_of(input t_idx a, input t_idx b);
        logic [IDX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[IDX_W:1];
    endfunction

endpackage

`default_nettype wire

FILE: sv/sbs_table.sv
`default_nettype none

module sbs_table (
    input  wire logic             i_clk,
    input  wire sbs_pkg::t_mem_req i_mem_req,
    output sbs_pkg::t_word        o_rd_data
);
    import sbs_pkg::*;

    t_word r_mem [TABLE_DEPTH];
    t_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_mem_req.we) begin
            r_mem[i_mem_req.waddr] <= i_mem_req.wdata;
        end
        r_rd_data <= r_mem[i_mem_req.raddr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: sv/sbs_seq.sv
`default_nettype none

module sbs_seq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_opcode,
    input  wire sbs_pkg::t_field   i_entry_index,
    input  wire sbs_pkg::t_word    i_entry_value,
    input  wire sbs_pkg::t_word    i_search_key,
    input  wire sbs_pkg::t_field   i_low_bound,
    input  wire sbs_pkg::t_field   i_high_bound,
    input  wire sbs_pkg::t_word    i_rd_data,
    output sbs_pkg::t_mem_req      o_mem_req,
    output logic                   o_busy,
    output logic                   o_result_valid,
    output logic                   o_found,
    output sbs_pkg::t_field        o_match_index
);
    import sbs_pkg::*;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_PROBE = 1'b1;

    logic   r_state, n_state;
    logic   r_res_valid, n_res_valid;
    logic   r_found, n_found;
    t_field r_match, n_match;
    t_idx   r_lo, n_lo;
    t_idx   r_hi, n_hi;
    t_idx   r_mid, n_mid;
    t_word  r_key, n_key;

    t_cmp   w_lo_ext;
    t_cmp   w_hi_ext;
    t_cmp   w_widx_ext;
    t_idx   w_mid_dec;
    t_idx   w_mid_inc;
    logic   w_accept;

    assign w_accept   = i_start && (r_state == ST_IDLE);
    assign w_lo_ext   = field_ext(i_low_bound);
    assign w_hi_ext   = (field_ext(i_high_bound) > LAST_IDX) ? LAST_IDX
                                                             : field_ext(i_high_bound);
    assign w_widx_ext = field_ext(i_entry_index);
    assign w_mid_dec  = r_mid - t_idx'(1);
    assign w_mid_inc  = r_mid + t_idx'(1);

    always_comb begin
        n_state     = r_state;
        n_res_valid = 1'b0;
        n_found     = r_found;
        n_match     = r_match;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_key       = r_key;

        case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_opcode == OP_SEARCH)) begin
                    if (w_lo_ext > w_hi_ext) begin
                        n_res_valid = 1'b1;
                        n_found     = 1'b0;
                        n_match     = '0;
                    end else begin
                        n_lo    = w_lo_ext[IDX_W-1:0];
                        n_hi    = w_hi_ext[IDX_W-1:0];
                        n_mid   = mid_of(w_lo_ext[IDX_W-1:0], w_hi_ext[IDX_W-1:0]);
                        n_key   = i_search_key;
                        n_state = ST_PROBE;
                    end
                end
            end
            ST_PROBE: begin
                if (i_rd_data == r_key) begin
                    n_res_valid = 1'b1;
                    n_found     = 1'b1;
                    n_match     = idx_to_field(r_mid);
                    n_state     = ST_IDLE;
                end else if (i_rd_data > r_key) begin
                    if (r_mid == r_lo) begin
                        n_res_valid = 1'b1;
                        n_found     = 1'b0;
                        n_match     = '0;
                        n_state     = ST_IDLE;
                    end else begin
                        n_hi  = w_mid_dec;
                        n_mid = mid_of(r_lo, w_mid_dec);
                    end
                end else begin
                    if (r_mid == r_hi) begin
                        n_res_valid = 1'b1;
                        n_found     = 1'b0;
                        n_match     = '0;
                        n_state     = ST_IDLE;
                    end else begin
                        n_lo  = w_mid_inc;
                        n_mid = mid_of(w_mid_inc, r_hi);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_found <= n_found;
        r_match <= n_match;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_key   <= n_key;
    end

    always_comb begin
        o_mem_req.we    = w_accept && (i_opcode == OP_WRITE) && (w_widx_ext <= LAST_IDX);
        o_mem_req.waddr = w_widx_ext[IDX_W-1:0];
        o_mem_req.wdata = i_entry_value;
        o_mem_req.raddr = n_mid;
    end

    assign o_busy         = (r_state == ST_PROBE);
    assign o_result_valid = r_res_valid;
    assign o_found        = r_found;
    assign o_match_index  = r_match;

endmodule

`default_nettype wire

FILE: sv/sorted_table_binary_search_unit.sv
`default_nettype none

// A write beat stores one word and gives no result; a search beat gives exactly one
// result, shown for a single cycle with o_result_valid, which the receiver must take
// since it cannot stall the block. A search occupies the block while it probes the
// table, at most nine probes for a 256-entry table, because each probe waits
// on the registered read of the single table memory; busy is high meanwhile. The
// result appears the cycle after the last probe, or the cycle after the beat when
// the range is empty. A write never raises busy.
module sorted_table_binary_search_unit (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire logic            i_opcode,
    input  wire sbs_pkg::t_field i_entry_index,
    input  wire sbs_pkg::t_word  i_entry_value,
    input  wire sbs_pkg::t_word  i_search_key,
    input  wire sbs_pkg::t_field i_low_bound,
    input  wire sbs_pkg::t_field i_high_bound,
    output logic                 o_result_valid,
    output logic                 o_found,
    output sbs_pkg::t_field      o_match_index
);
    import sbs_pkg::*;

    t_mem_req w_mem_req;
    t_word    w_rd_data;

    sbs_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_opcode       (i_opcode),
        .i_entry_index  (i_entry_index),
        .i_entry_value  (i_entry_value),
        .i_search_key   (i_search_key),
        .i_low_bound    (i_low_bound),
        .i_high_bound   (i_high_bound),
        .i_rd_data      (w_rd_data),
        .o_mem_req      (w_mem_req),
        .o_busy         (busy),
        .o_result_valid (o_result_valid),
        .o_found        (o_found),
        .o_match_index  (o_match_index)
    );

    sbs_table u_table (
        .i_clk     (i_clk),
        .i_mem_req (w_mem_req),
        .o_rd_data (w_rd_data)
    );

endmodule

`default_nettype wire
